>>> design/pvr_pkg.sv
// ----------------------------------------------------------------------------
// pvr_pkg
// Shared types, sizes and codes for the primitive voxel rasterizer.
// ----------------------------------------------------------------------------
package pvr_pkg;

  localparam int MAX_X      = 64;
  localparam int MAX_Y      = 64;
  localparam int MAX_Z      = 16;
  localparam int GRID_CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int GRID_AW    = $clog2(GRID_CELLS);

  // doubled voxel center and its distance to the doubled shape center
  localparam int CW   = 41;
  // magnitude of that distance, its square and the sum of three squares
  localparam int MW   = 40;
  localparam int SQW  = 80;
  localparam int SUMW = 82;
  localparam int PIPE = 5;

  localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

  localparam logic [2:0] FUNC_BOX    = 3'd0;
  localparam logic [2:0] FUNC_SPHERE = 3'd1;
  localparam logic [2:0] FUNC_CYL    = 3'd2;
  localparam logic [2:0] FUNC_WRITE  = 3'd3;
  localparam logic [2:0] FUNC_READ   = 3'd4;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_STEP_XY  = 3'd3;
  localparam logic [2:0] REG_STEP_Z   = 3'd4;
  localparam logic [2:0] REG_CELLS_X  = 3'd5;
  localparam logic [2:0] REG_CELLS_Y  = 3'd6;
  localparam logic [2:0] REG_CELLS_Z  = 3'd7;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_ZERO,
    RES_COUNT,
    RES_VOX
  } res_sel_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [30:0]        extent_x;
    logic [30:0]        extent_y;
    logic [30:0]        extent_z;
    logic [7:0]         cost;
    logic signed [15:0] voxel_x;
    logic signed [15:0] voxel_y;
    logic signed [15:0] voxel_z;
  } in_t;

  typedef struct packed {
    logic [16:0] marked_count;
    logic [7:0]  read_value;
    logic        in_range;
  } out_t;

  typedef struct packed {
    logic     load;
    logic     setup;
    logic     issue;
    logic     mark;
    logic     vox_addr;
    logic     vox_exec;
    res_sel_e res_sel;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic pipe_busy;
  } status_t;

endpackage

>>> design/pvr_ram.sv
// ----------------------------------------------------------------------------
// pvr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module pvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic                     we_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pvr_ctrl.sv
// ----------------------------------------------------------------------------
// pvr_ctrl
// Sequencer for the clearing pass, shape sweeps and single-voxel accesses.
// ----------------------------------------------------------------------------
module pvr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic [2:0]       func_i,
  input  pvr_pkg::status_t status_i,
  output pvr_pkg::cmd_t    cmd_o,
  output logic             busy,
  output logic             done_o
);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_CLR_DRAIN = 4'd1;
  localparam logic [3:0] ST_IDLE      = 4'd2;
  localparam logic [3:0] ST_SETUP     = 4'd3;
  localparam logic [3:0] ST_SWEEP     = 4'd4;
  localparam logic [3:0] ST_DRAIN     = 4'd5;
  localparam logic [3:0] ST_VADDR     = 4'd6;
  localparam logic [3:0] ST_VEXEC     = 4'd7;
  localparam logic [3:0] ST_VREAD     = 4'd8;

  logic [3:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    cmd_o.res_sel = pvr_pkg::RES_HOLD;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.issue = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_CLR_DRAIN;
        end
      end
      ST_CLR_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          if (func_i == pvr_pkg::FUNC_BOX || func_i == pvr_pkg::FUNC_SPHERE ||
              func_i == pvr_pkg::FUNC_CYL) begin
            state_d = ST_SETUP;
          end else if (func_i == pvr_pkg::FUNC_WRITE || func_i == pvr_pkg::FUNC_READ) begin
            state_d = ST_VADDR;
          end else begin
            // unknown command: empty result right away
            cmd_o.res_sel = pvr_pkg::RES_ZERO;
            done_d        = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd_o.issue = 1'b1;
        cmd_o.mark  = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.res_sel = pvr_pkg::RES_COUNT;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_VADDR: begin
        cmd_o.vox_addr = 1'b1;
        state_d        = ST_VEXEC;
      end
      ST_VEXEC: begin
        cmd_o.vox_exec = 1'b1;
        state_d        = ST_VREAD;
      end
      ST_VREAD: begin
        cmd_o.res_sel = pvr_pkg::RES_VOX;
        done_d        = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == ST_IDLE)
    else $error("result strobe outside idle");

  a_setup_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SETUP |-> $past(state_q) == ST_IDLE)
    else $error("sweep setup without accepted command");

  a_vread_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_VREAD |-> $past(state_q) == ST_VEXEC)
    else $error("voxel result without memory access");

  a_drain_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && !status_i.pipe_busy) |=> !status_i.pipe_busy)
    else $error("sweep pipeline active after drain");
`endif

endmodule

>>> design/pvr_datapath.sv
// ----------------------------------------------------------------------------
// pvr_datapath
// Configuration registers, sweep counters, inside-test pipeline, cost grid
// and result register.
// ----------------------------------------------------------------------------
module pvr_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  pvr_pkg::in_t       item_i,
  input  pvr_pkg::cmd_t      cmd_i,
  output pvr_pkg::status_t   status_o,
  output pvr_pkg::out_t      result_o
);

  localparam int CW   = pvr_pkg::CW;
  localparam int MW   = pvr_pkg::MW;
  localparam int SQW  = pvr_pkg::SQW;
  localparam int SUMW = pvr_pkg::SUMW;
  localparam int AW   = pvr_pkg::GRID_AW;
  localparam int PIPE = pvr_pkg::PIPE;

  // configuration
  logic signed [31:0] ox_q, oy_q, oz_q;
  logic [30:0]        sxy_q, sz_q;
  logic [6:0]         ncx_q, ncy_q;
  logic [4:0]         ncz_q;
  logic [6:0]         cx_eff, cy_eff;
  logic [4:0]         cz_eff;
  logic [13:0]        cxy_q;

  pvr_pkg::in_t item_q;
  pvr_pkg::out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ox_q  <= '0;
      oy_q  <= '0;
      oz_q  <= '0;
      sxy_q <= 31'd65536;
      sz_q  <= 31'd65536;
      ncx_q <= 7'd64;
      ncy_q <= 7'd64;
      ncz_q <= 5'd16;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pvr_pkg::REG_ORIGIN_X: ox_q  <= cfg_data_i;
        pvr_pkg::REG_ORIGIN_Y: oy_q  <= cfg_data_i;
        pvr_pkg::REG_ORIGIN_Z: oz_q  <= cfg_data_i;
        pvr_pkg::REG_STEP_XY:  sxy_q <= cfg_data_i[30:0];
        pvr_pkg::REG_STEP_Z:   sz_q  <= cfg_data_i[30:0];
        pvr_pkg::REG_CELLS_X:  ncx_q <= cfg_data_i[6:0];
        pvr_pkg::REG_CELLS_Y:  ncy_q <= cfg_data_i[6:0];
        pvr_pkg::REG_CELLS_Z:  ncz_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign cx_eff = (ncx_q > 7'(pvr_pkg::MAX_X)) ? 7'(pvr_pkg::MAX_X) : ncx_q;
  assign cy_eff = (ncy_q > 7'(pvr_pkg::MAX_Y)) ? 7'(pvr_pkg::MAX_Y) : ncy_q;
  assign cz_eff = (ncz_q > 5'(pvr_pkg::MAX_Z)) ? 5'(pvr_pkg::MAX_Z) : ncz_q;

  always_ff @(posedge clk_i) begin
    cxy_q <= 14'(cx_eff) * 14'(cy_eff);
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // ---------------------------------------------------------------- sweep
  logic signed [CW-1:0] wxi, wyi, wzi;
  logic signed [CW-1:0] wx_q, wy_q, wz_q, wxi_q, wyi_q;
  logic [CW-1:0]        dxy, dz;
  logic [63:0]          lim_q;
  logic [31:0]          r2;
  logic [30:0]          ezsel_q;
  logic [AW-1:0]        addr_q;
  logic [6:0]           x_q, y_q;
  logic [4:0]           z_q;
  logic                 in_use;

  assign wxi = CW'($signed({ox_q, 1'b0})) + CW'(sxy_q);
  assign wyi = CW'($signed({oy_q, 1'b0})) + CW'(sxy_q);
  assign wzi = CW'($signed({oz_q, 1'b0})) + CW'(sz_q);
  assign dxy = CW'({sxy_q, 1'b0});
  assign dz  = CW'({sz_q, 1'b0});
  assign r2  = {item_q.extent_x, 1'b0};
  assign in_use = (cx_eff != '0) && (cy_eff != '0) && (z_q < cz_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else if (cmd_i.setup) begin
      x_q <= '0;
      y_q <= '0;
      z_q <= '0;
    end else if (cmd_i.issue) begin
      addr_q <= addr_q + AW'(1);
      if (in_use) begin
        if (x_q + 7'd1 == cx_eff) begin
          x_q <= '0;
          if (y_q + 7'd1 == cy_eff) begin
            y_q <= '0;
            z_q <= z_q + 5'd1;
          end else begin
            y_q <= y_q + 7'd1;
          end
        end else begin
          x_q <= x_q + 7'd1;
        end
      end
    end
  end

  // doubled voxel centers follow the counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      wx_q    <= wxi;
      wy_q    <= wyi;
      wz_q    <= wzi;
      wxi_q   <= wxi;
      wyi_q   <= wyi;
      lim_q   <= 64'(r2) * 64'(r2);
      ezsel_q <= (item_q.func == pvr_pkg::FUNC_CYL) ? item_q.extent_y : item_q.extent_z;
    end else if (cmd_i.issue && in_use) begin
      if (x_q + 7'd1 == cx_eff) begin
        wx_q <= wxi_q;
        if (y_q + 7'd1 == cy_eff) begin
          wy_q <= wyi_q;
          wz_q <= wz_q + dz;
        end else begin
          wy_q <= wy_q + dxy;
        end
      end else begin
        wx_q <= wx_q + dxy;
      end
    end
  end

  assign status_o.sweep_last = (addr_q == '1);

  // ------------------------------------------------------------- pipeline
  logic [PIPE-1:0]       pv_q, pu_q;
  logic [AW-1:0]         pa_q [PIPE];
  logic signed [CW-1:0]  c2 [3];
  logic signed [CW-1:0]  w [3];
  logic [30:0]           ext [3];
  logic signed [CW-1:0]  dd_q [3];
  logic [MW-1:0]         mg_q [3];
  logic [CW-1:0]         negd [3];
  logic [63:0]           ll_q [3];
  logic [39:0]           lh_q [3];
  logic [15:0]           hh_q [3];
  logic [2:0]            bx3_q;
  logic [SQW-1:0]        sq_q [3];
  logic                  box4_q, bz4_q, box5_q, bz5_q;
  logic [SUMW-1:0]       sum5_q;
  logic                  hit;
  logic                  cost_zero;

  assign c2[0] = CW'($signed({item_q.pos_x, 1'b0}));
  assign c2[1] = CW'($signed({item_q.pos_y, 1'b0}));
  assign c2[2] = CW'($signed({item_q.pos_z, 1'b0}));
  assign w[0]  = wx_q;
  assign w[1]  = wy_q;
  assign w[2]  = wz_q;
  assign ext[0] = item_q.extent_x;
  assign ext[1] = item_q.extent_y;
  assign ext[2] = ezsel_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      negd[a] = -dd_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
    end else begin
      pv_q <= {pv_q[PIPE-2:0], cmd_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    pu_q  <= {pu_q[PIPE-2:0], in_use & cmd_i.mark};
    pa_q[0] <= addr_q;
    for (int s = 1; s < PIPE; s++) begin
      pa_q[s] <= pa_q[s-1];
    end
    for (int a = 0; a < 3; a++) begin
      dd_q[a]  <= w[a] - c2[a];
      mg_q[a]  <= dd_q[a][CW-1] ? MW'(negd[a]) : MW'(dd_q[a]);
      ll_q[a]  <= 64'(mg_q[a][31:0]) * 64'(mg_q[a][31:0]);
      lh_q[a]  <= 40'(mg_q[a][31:0]) * 40'(mg_q[a][MW-1:32]);
      hh_q[a]  <= 16'(mg_q[a][MW-1:32]) * 16'(mg_q[a][MW-1:32]);
      bx3_q[a] <= (mg_q[a] <= MW'(ext[a]));
      sq_q[a]  <= (SQW'(hh_q[a]) << 64) + (SQW'(lh_q[a]) << 33) + SQW'(ll_q[a]);
    end
    box4_q <= &bx3_q;
    bz4_q  <= bx3_q[2];
    sum5_q <= SUMW'(sq_q[0]) + SUMW'(sq_q[1]) +
              ((item_q.func == pvr_pkg::FUNC_SPHERE) ? SUMW'(sq_q[2]) : '0);
    box5_q <= box4_q;
    bz5_q  <= bz4_q;
  end

  always_comb begin
    if (item_q.func == pvr_pkg::FUNC_BOX) begin
      hit = box5_q;
    end else if (item_q.func == pvr_pkg::FUNC_CYL) begin
      hit = (sum5_q <= SUMW'(lim_q)) && bz5_q;
    end else begin
      hit = (sum5_q <= SUMW'(lim_q));
    end
  end

  assign status_o.pipe_busy = |pv_q;
  assign cost_zero = (item_q.cost == 8'd0);

  // ----------------------------------------------------------- grid, count
  logic [AW-1:0] idx_q, idx_d, ram_addr;
  logic          inr_q, inr_d;
  logic          ram_we;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [16:0]   cnt_q;

  assign inr_d = !item_q.voxel_x[15] && !item_q.voxel_y[15] && !item_q.voxel_z[15] &&
                 (item_q.voxel_x[14:0] < 15'(cx_eff)) &&
                 (item_q.voxel_y[14:0] < 15'(cy_eff)) &&
                 (item_q.voxel_z[14:0] < 15'(cz_eff));
  assign idx_d = AW'(AW'(item_q.voxel_z) * AW'(cxy_q)) +
                 AW'(AW'(item_q.voxel_y) * AW'(cx_eff)) + AW'(item_q.voxel_x);

  always_ff @(posedge clk_i) begin
    if (cmd_i.vox_addr) begin
      idx_q <= idx_d;
      inr_q <= inr_d;
    end
  end

  always_comb begin
    if (cmd_i.vox_exec) begin
      ram_addr  = idx_q;
      ram_we    = inr_q && (item_q.func == pvr_pkg::FUNC_WRITE);
      ram_wdata = item_q.cost;
    end else begin
      ram_addr  = pa_q[PIPE-1];
      ram_we    = pv_q[PIPE-1];
      ram_wdata = (pu_q[PIPE-1] && hit) ? item_q.cost : 8'd0;
    end
  end

  pvr_ram #(
    .WIDTH (8),
    .DEPTH (pvr_pkg::GRID_CELLS)
  ) u_grid (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.setup) begin
      cnt_q <= '0;
    end else if (pv_q[PIPE-1] && pu_q[PIPE-1] && (hit || cost_zero) &&
                 cnt_q != pvr_pkg::COUNT_MAX) begin
      cnt_q <= cnt_q + 17'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res_sel)
      pvr_pkg::RES_HOLD:  res_q <= res_q;
      pvr_pkg::RES_ZERO:  res_q <= '0;
      pvr_pkg::RES_COUNT: res_q <= '{marked_count: cnt_q, read_value: 8'd0, in_range: 1'b0};
      pvr_pkg::RES_VOX: begin
        res_q <= '{marked_count: 17'd0,
                   read_value: (inr_q && item_q.func == pvr_pkg::FUNC_READ) ?
                               ram_rdata : 8'd0,
                   in_range: inr_q};
      end
      default: res_q <= res_q;
    endcase
  end

  assign result_o = res_q;

endmodule

>>> design/primitive_voxel_rasterizer.sv
// ----------------------------------------------------------------------------
// primitive_voxel_rasterizer
// Voxel cost grid with box, sphere and z-cylinder rasterization.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 65536-entry cost grid to zero, one entry
// per cycle, with busy high until that clearing pass has drained. A shape
// command (box, sphere, cylinder) takes a setup step, then a sweep over the
// whole grid through the single grid memory port, whatever the cell counts,
// then a drain of the inside-test pipeline before done_o rises. A voxel write
// or read takes an address step, a memory access and a registered read. An
// unknown command returns an all-zero result in the next cycle. Each
// transaction is started by start while busy is low and ends with exactly
// one cycle of done_o with result_o valid; the receiver cannot stall, so the
// result must be taken in that cycle.
// ----------------------------------------------------------------------------
module primitive_voxel_rasterizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pvr_pkg::in_t  item_i,
  output logic          done_o,
  output pvr_pkg::out_t result_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i
);

  pvr_pkg::cmd_t    cmd;
  pvr_pkg::status_t status;

  pvr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .func_i   (item_i.func),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  pvr_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .result_o   (result_o)
  );

endmodule
